@@ design/somc_pkg.sv @@
// Shared types and constants for the sphere clearance core.
`default_nettype none
package somc_pkg;
   localparam int COORD_W = 24;
   localparam int RAD_W   = 23;
   localparam int CLR_W   = 25;
   localparam int DIFF_W  = 25;
   localparam int SQ_W    = 50;
   localparam int SUM_W   = 52;
   localparam int ROOT_W  = 26;
   localparam logic signed [CLR_W-1:0] CLR_MAX = 25'sh0FFFFFF;

   typedef enum logic [1:0] {
      FUNC_CLEAR = 2'd0,
      FUNC_LOAD  = 2'd1,
      FUNC_QUERY = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [RAD_W-1:0]          r;
   } sphere_type;
endpackage
`default_nettype wire

@@ design/somc_isqrt.sv @@
// Iterative floor square root, two radicand bits and one root bit per cycle.
`default_nettype none
module somc_isqrt
   import somc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [SUM_W-1:0]  value,
   output logic                   done,
   output logic [ROOT_W-1:0]      root
);
   localparam int STEPS = SUM_W / 2;

   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  val_ff, val_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [SUM_W-1:0]  trial;
   logic [SUM_W-1:0]  shifted;

   // One restoring step: bring down two bits, try 4*root+1.
   always_comb begin
      shifted = {rem_ff[SUM_W-3:0], val_ff[SUM_W-1 -: 2]};
      trial   = SUM_W'({root_ff[ROOT_W-1:0], 2'b01});
      rem_in  = rem_ff;
      val_in  = val_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         val_in  = value;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in = {val_ff[SUM_W-3:0], 2'b00};
         if (shifted >= trial) begin
            rem_in  = shifted - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      val_ff  <= val_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule
`default_nettype wire

@@ design/sphere_obstacle_min_clearance_core.sv @@
// Top level of the sphere clearance core: table, sequencer and shared units.
// One item at a time. Clear, load and ignored codes are taken in their
// accepting cycle, so the next item can follow in the next cycle. A query
// visits each stored obstacle in turn: a table read, the three squares on one
// shared 25x25 squaring multiplier, the sum finished, then a root start,
// 26 steps of the shared square root unit and a fold. A query holds the input
// until every stored obstacle is done, and longer while a finished clearance
// still waits for rsp_ready.
// The table has one write and one read port; reset does not clear it.
`default_nettype none
module sphere_obstacle_min_clearance_core
   import somc_pkg::*;
#(
   parameter int MAX_OBSTACLES = 64
)(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [1:0]                req_func,
   input  wire logic signed [COORD_W-1:0] req_pos_x,
   input  wire logic signed [COORD_W-1:0] req_pos_y,
   input  wire logic signed [COORD_W-1:0] req_pos_z,
   input  wire logic [RAD_W-1:0]          req_radius,
   input  wire logic                      req_last_sphere,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [CLR_W-1:0]        rsp_clearance
);
   localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
   localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_MUL_X, S_MUL_Y, S_MUL_Z, S_ROOT, S_FOLD, S_DONE
   } state_type;

   state_type              state_ff, state_in;
   sphere_type             table_mem [MAX_OBSTACLES];
   sphere_type             obs_ff;
   sphere_type             robot_ff, robot_in;
   logic                   last_ff, last_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic signed [CLR_W-1:0] min_ff, min_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [SQ_W-1:0]        sq_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [CLR_W-1:0] rsp_clr_ff, rsp_clr_in;
   logic                   wr_en;
   logic signed [DIFF_W-1:0] diff;
   logic                   root_start, root_done;
   logic                   root_go_ff;
   logic [ROOT_W-1:0]      root;
   logic signed [ROOT_W+1:0] gap;
   logic signed [CLR_W-1:0]  gap_sat;

   // Memory: one write and one registered read per cycle.
   assign wr_en = (state_ff == S_IDLE) && req_valid && (req_func == FUNC_LOAD)
                  && (count_ff < CNT_W'(MAX_OBSTACLES));
   always_ff @(posedge clock) begin
      if (wr_en)
         table_mem[count_ff[IDX_W-1:0]] <= {req_pos_x, req_pos_y, req_pos_z, req_radius};
      obs_ff <= table_mem[idx_ff[IDX_W-1:0]];
   end

   // Shared subtract and square.
   always_comb begin
      unique case (state_ff)
         S_MUL_X: diff = DIFF_W'(robot_ff.x) - DIFF_W'(obs_ff.x);
         S_MUL_Y: diff = DIFF_W'(robot_ff.y) - DIFF_W'(obs_ff.y);
         default: diff = DIFF_W'(robot_ff.z) - DIFF_W'(obs_ff.z);
      endcase
   end
   always_ff @(posedge clock) sq_ff <= SQ_W'(diff * diff);

   somc_isqrt u_isqrt (
      .clock (clock), .reset (reset), .start (root_start),
      .value (sum_ff), .done (root_done), .root (root)
   );

   // Gap and saturation.
   always_comb begin
      gap = $signed({2'b00, root}) - $signed((ROOT_W+2)'(robot_ff.r))
            - $signed((ROOT_W+2)'(obs_ff.r));
      gap_sat = (gap > (ROOT_W+2)'(CLR_MAX)) ? CLR_MAX : CLR_W'(gap);
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      robot_in     = robot_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      min_in       = min_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_clr_in   = rsp_clr_ff;
      root_start   = root_go_ff;
      if (rsp_valid_ff && rsp_ready)
         rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: if (req_valid) begin
            robot_in = {req_pos_x, req_pos_y, req_pos_z, req_radius};
            last_in  = req_last_sphere;
            idx_in   = '0;
            unique case (req_func)
               FUNC_CLEAR: count_in = '0;
               FUNC_LOAD:  if (wr_en) count_in = count_ff + CNT_W'(1);
               FUNC_QUERY: state_in = S_READ;
               default: ;
            endcase
            if (req_func != FUNC_QUERY) state_in = S_IDLE;
         end
         S_READ: begin
            if (idx_ff == count_ff) state_in = S_DONE;
            else                    state_in = S_MUL_X;
         end
         S_MUL_X: state_in = S_MUL_Y;
         S_MUL_Y: begin
            sum_in   = SUM_W'(sq_ff);
            state_in = S_MUL_Z;
         end
         S_MUL_Z: begin
            sum_in   = sum_ff + SUM_W'(sq_ff);
            state_in = S_MUL_Z == S_MUL_Z ? S_ROOT : S_ROOT;
         end
         S_ROOT: begin
            // z square lands here; the root starts on the next cycle.
            sum_in   = sum_ff + SUM_W'(sq_ff);
            state_in = S_FOLD;
         end
         S_FOLD: if (root_done) begin
            if (gap_sat < min_ff) min_in = gap_sat;
            idx_in   = idx_ff + CNT_W'(1);
            state_in = S_READ;
         end
         S_DONE: begin
            if (!last_ff) state_in = S_IDLE;
            else if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_clr_in   = min_ff;
               min_in       = CLR_MAX;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Start the root in the cycle after S_ROOT, once the sum is complete.
   always_ff @(posedge clock) begin
      if (reset) root_go_ff <= 1'b0;
      else       root_go_ff <= (state_ff == S_ROOT);
   end

   always_ff @(posedge clock) begin
      robot_ff   <= robot_in;
      last_ff    <= last_in;
      idx_ff     <= idx_in;
      sum_ff     <= sum_in;
      rsp_clr_ff <= rsp_clr_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         min_ff       <= CLR_MAX;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         min_ff       <= min_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_clearance = rsp_clr_ff;
endmodule
`default_nettype wire

@@ verif/sphere_obstacle_min_clearance_core_test.sv @@
// Testbench for the sphere clearance core: directed table, random configurations, scoreboard.
`default_nettype none
module sphere_obstacle_min_clearance_core_test;
   import somc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = 64;
   localparam int ITEM_TARGET = 1550;
   localparam int CYCLE_LIMIT = 20000000;
   localparam int DRAIN_CYCLES = 2200;

   typedef struct {
      func_type                  func;
      logic [COORD_W-1:0]        x;
      logic [COORD_W-1:0]        y;
      logic [COORD_W-1:0]        z;
      logic [RAD_W-1:0]          r;
      bit                        last;
      bit                        has_known;
      logic signed [CLR_W-1:0]   known;
   } stim_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [1:0] req_func;
   logic signed [COORD_W-1:0] req_pos_x;
   logic signed [COORD_W-1:0] req_pos_y;
   logic signed [COORD_W-1:0] req_pos_z;
   logic [RAD_W-1:0] req_radius;
   logic req_last_sphere;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [CLR_W-1:0] rsp_clearance;

   // model of the obstacle store and the running minimum
   sphere_type obstacles [TABLE_DEPTH];
   int obstacle_total;
   logic signed [CLR_W-1:0] min_gap;

   logic signed [CLR_W-1:0] pending_clearance [$];
   int errors = 0;
   int items_sent = 0;
   int clearances_seen = 0;
   int full_tables = 0;
   int cycles = 0;
   int req_idle_pct = 12;
   int rsp_idle_pct = 54;
   int rsp_hold_left = 0;

   stim_row_type directed [19] = '{
      '{FUNC_QUERY, 24'h0, 24'h0, 24'h0, 23'h0, 1, 1, CLR_MAX},
      '{FUNC_NONE, 24'h1, 24'h1, 24'h1, 23'h1, 1, 0, 0},
      '{FUNC_LOAD, 24'h0, 24'h0, 24'h0, 23'h0, 0, 0, 0},
      '{FUNC_QUERY, 24'd196608, 24'd262144, 24'h0, 23'h0, 1, 1, 25'sd327680},
      '{FUNC_QUERY, 24'h0, 24'h0, 24'h0, 23'd65536, 0, 0, 0},
      '{FUNC_QUERY, 24'h0, 24'h0, 24'h0, 23'h0, 1, 1, -25'sd65536},
      '{FUNC_CLEAR, 24'h0, 24'h0, 24'h0, 23'h0, 1, 0, 0},
      '{FUNC_QUERY, 24'h0, 24'h0, 24'h0, 23'h0, 1, 1, CLR_MAX},
      '{FUNC_LOAD, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF, 0, 0, 0},
      '{FUNC_QUERY, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF, 1, 1, -25'sd16777214},
      '{FUNC_CLEAR, 24'h0, 24'h0, 24'h0, 23'h0, 0, 0, 0},
      '{FUNC_LOAD, 24'h800000, 24'h800000, 24'h800000, 23'h0, 1, 0, 0},
      '{FUNC_QUERY, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 23'h0, 1, 1, CLR_MAX},
      '{FUNC_LOAD, 24'h0, 24'h0, 24'h0, 23'h7FFFFF, 0, 0, 0},
      '{FUNC_QUERY, 24'h800000, 24'h800000, 24'h800000, 23'h0, 1, 1, 25'sd0},
      '{FUNC_QUERY, 24'hFFFFFF, 24'h000001, 24'h0, 23'h555555, 0, 0, 0},
      '{FUNC_QUERY, 24'hAAAAAA, 24'h555555, 24'h7FFFFF, 23'h2AAAAA, 1, 0, 0},
      '{FUNC_NONE, 24'h0, 24'h0, 24'h0, 23'h0, 0, 0, 0},
      '{FUNC_CLEAR, 24'h0, 24'h0, 24'h0, 23'h0, 0, 0, 0}
   };

   sphere_obstacle_min_clearance_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_pos_z(req_pos_z),
      .req_radius(req_radius),
      .req_last_sphere(req_last_sphere),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_clearance(rsp_clearance)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // floor square root, bit by bit
   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned res;
      longint unsigned bitpos;
      res = 0;
      bitpos = 64'd1 << 62;
      while (bitpos > v) bitpos >>= 2;
      while (bitpos != 0) begin
         if (v >= res + bitpos) begin
            v -= res + bitpos;
            res = (res >> 1) + bitpos;
         end else begin
            res >>= 1;
         end
         bitpos >>= 2;
      end
      return res;
   endfunction

   // signed gap between a robot sphere and one obstacle, saturated high
   function automatic longint sphere_gap(sphere_type a, sphere_type b);
      longint dx, dy, dz, g;
      dx = longint'(a.x) - longint'(b.x);
      dy = longint'(a.y) - longint'(b.y);
      dz = longint'(a.z) - longint'(b.z);
      g = longint'(floor_root(longint'(dx * dx + dy * dy + dz * dz)))
          - longint'(a.r) - longint'(b.r);
      if (g > longint'(CLR_MAX)) g = longint'(CLR_MAX);
      return g;
   endfunction

   // advance the model by one transfer; report whether a clearance comes out
   function automatic bit update_clearance(stim_row_type row,
                                           output logic signed [CLR_W-1:0] value);
      sphere_type s;
      longint g;
      s.x = row.x;
      s.y = row.y;
      s.z = row.z;
      s.r = row.r;
      value = '0;
      case (row.func)
         FUNC_CLEAR: begin
            obstacle_total = 0;
            return 0;
         end
         FUNC_LOAD: begin
            if (obstacle_total < TABLE_DEPTH) begin
               obstacles[obstacle_total] = s;
               obstacle_total++;
            end
            return 0;
         end
         FUNC_QUERY: begin
            for (int i = 0; i < obstacle_total; i++) begin
               g = sphere_gap(s, obstacles[i]);
               if (g < longint'(min_gap)) min_gap = CLR_W'(g);
            end
            if (!row.last) return 0;
            value = min_gap;
            min_gap = CLR_MAX;
            return 1;
         end
         default: return 0;
      endcase
   endfunction

   // present one item, hold it until the transfer, then update the expectations
   task automatic send_item(stim_row_type row);
      logic signed [CLR_W-1:0] predicted;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid = 1;
      req_func = row.func;
      req_pos_x = row.x;
      req_pos_y = row.y;
      req_pos_z = row.z;
      req_radius = row.r;
      req_last_sphere = row.last;
      do @(posedge clock); while (!req_ready);
      if (row.func == FUNC_QUERY && obstacle_total == TABLE_DEPTH) full_tables++;
      if (update_clearance(row, predicted))
         pending_clearance = {pending_clearance, (row.has_known ? row.known : predicted)};
      items_sent++;
      @(negedge clock);
   endtask

   // coordinate near a chosen center, or anywhere
   function automatic logic [COORD_W-1:0] pick_coord(logic [COORD_W-1:0] center);
      if ($urandom_range(3) == 0) return COORD_W'($urandom);
      return center + COORD_W'(int'($urandom_range(1 << 19)) - (1 << 18));
   endfunction

   function automatic stim_row_type random_sphere(func_type f, logic [COORD_W-1:0] center,
                                                  bit last);
      stim_row_type row;
      row.func = f;
      row.x = pick_coord(center);
      row.y = pick_coord(center);
      row.z = pick_coord(center);
      row.r = ($urandom_range(3) == 0) ? RAD_W'($urandom) : RAD_W'($urandom_range(1 << 17));
      row.last = last;
      row.has_known = 0;
      row.known = '0;
      return row;
   endfunction

   // one obstacle set followed by one robot pose, with some noise mixed in
   task automatic random_configuration();
      logic [COORD_W-1:0] center;
      int loads, queries;
      center = COORD_W'($urandom);
      if ($urandom_range(99) < 85) send_item(random_sphere(FUNC_CLEAR, center, 1'($urandom)));
      loads = ($urandom_range(99) < 4) ? $urandom_range(60, 70) : $urandom_range(0, 6);
      for (int i = 0; i < loads; i++)
         send_item(random_sphere(FUNC_LOAD, center, 1'($urandom)));
      queries = $urandom_range(1, 4);
      for (int i = 0; i < queries; i++) begin
         if ($urandom_range(99) < 8)
            send_item(random_sphere($urandom_range(1) ? FUNC_NONE : FUNC_QUERY, center,
                                    1'($urandom)));
         send_item(random_sphere(FUNC_QUERY, center, i == queries - 1));
      end
   endtask

   // receiver: random stalls plus one long hold-off
   initial begin
      rsp_ready = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_ready = 0;
            rsp_hold_left--;
         end else begin
            rsp_ready = ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // compare each clearance transfer with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_clearance.size() == 0) begin
            $display("%0t: unexpected clearance, expected none, actual %0d", $time,
                     rsp_clearance);
            errors++;
         end else begin
            if (rsp_clearance !== pending_clearance[0]) begin
               $display("%0t: clearance mismatch, expected %0d, actual %0d", $time,
                        pending_clearance[0], rsp_clearance);
               errors++;
            end
            void'(pending_clearance.pop_front());
            clearances_seen++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL sphere_obstacle_min_clearance_core");
         $finish;
      end
   end

   initial begin
      int drain;
      reset = 1;
      req_valid = 0;
      req_func = FUNC_NONE;
      req_pos_x = '0;
      req_pos_y = '0;
      req_pos_z = '0;
      req_radius = '0;
      req_last_sphere = 0;
      obstacle_total = 0;
      min_gap = CLR_MAX;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed items
      foreach (directed[i]) send_item(directed[i]);

      // random configurations in three idling phases
      while (items_sent < ITEM_TARGET / 3) random_configuration();
      req_idle_pct = 54;
      rsp_idle_pct = 12;
      while (items_sent < 2 * ITEM_TARGET / 3) random_configuration();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      rsp_hold_left = 500;
      while (items_sent < ITEM_TARGET) random_configuration();
      req_valid = 0;

      // drain outstanding clearances, then allow the longest query to finish
      drain = 0;
      while (pending_clearance.size() != 0 && drain < CYCLE_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_clearance.size() != 0) begin
         $display("%0t: %0d clearances never arrived", $time, pending_clearance.size());
         errors++;
      end

      $display("Sent %0d items, checked %0d clearances, %0d queries against a full table.",
               items_sent, clearances_seen, full_tables);
      $display("Mismatches: %0d", errors);
      if (errors == 0)
         $display("PASS sphere_obstacle_min_clearance_core");
      else
         $display("FAIL sphere_obstacle_min_clearance_core");
      $finish;
   end
endmodule
`default_nettype wire

@@ sim.f @@
design/somc_pkg.sv
design/somc_isqrt.sv
design/sphere_obstacle_min_clearance_core.sv
verif/sphere_obstacle_min_clearance_core_test.sv
